// ===== rtl/qn_pkg.sv =====
// Shared types, constants and the per-bit step of the reciprocal square root search.
// Used by every module of quaternion_normalize.
package qn_pkg;

  localparam int unsigned CompW  = 16;
  localparam int unsigned FracB  = 14;
  localparam int unsigned RegW   = 33;
  localparam int unsigned SqW    = 2 * CompW;
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned NumStg = FracB + 1;
  localparam int unsigned AccW   = 2 * SumW;
  localparam int unsigned NumC   = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [0:0] RegZeroThr = 1'b0;
  localparam logic [0:0] RegChgTol  = 1'b1;
  localparam logic [RegW-1:0] ChgTolRst = RegW'(2684);
  localparam logic [SumW:0] OneQ = (SumW+1)'(1) << (2 * FracB);

  typedef struct packed {
    logic [NumC-1:0]            neg;
    logic [NumC-1:0][SqW-1:0]   sq;
    logic [SumW-1:0]            sum;
    logic                       ident;
    logic                       chg;
  } item_t;

  typedef struct packed {
    logic [AccW-1:0] acc_a;
    logic [AccW-1:0] acc_b;
  } acc_t;

  // Tests candidate bit b of the scaled result given a = u^2*S, b_in = u*S, u = 2r.
  function automatic logic try_bit(input logic [AccW-1:0] a, input logic [AccW-1:0] b_in,
                                   input logic [AccW-1:0] s, input logic [AccW-1:0] m,
                                   input int unsigned bp);
    logic [AccW-1:0] t;
    t = a + (b_in << (bp + 2)) - (b_in << 1) + (s << (2 * bp + 2)) - (s << (bp + 2)) + s;
    return t <= m;
  endfunction

  function automatic acc_t take_bit(input acc_t cur, input logic [AccW-1:0] s,
                                    input int unsigned bp);
    acc_t nxt;
    nxt.acc_a = cur.acc_a + (cur.acc_b << (bp + 2)) + (s << (2 * bp + 2));
    nxt.acc_b = cur.acc_b + (s << (bp + 1));
    return nxt;
  endfunction

endpackage

// ===== rtl/qn_front.sv =====
// Front end: squares the components, sums them and classifies the word.
// Depends on qn_pkg.
module qn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [63:0]          data_i,
  input  logic [qn_pkg::RegW-1:0] zero_thr_i,
  input  logic [qn_pkg::RegW-1:0] chg_tol_i,
  output logic                 vld_o,
  output qn_pkg::item_t        item_o
);
  import qn_pkg::*;

  logic                       s1_vld_q;
  logic [NumC-1:0]            s1_neg_q;
  logic [NumC-1:0][SqW-1:0]   s1_sq_q;
  logic                       s2_vld_q;
  item_t                      s2_q;
  logic [NumC-1:0][CompW-1:0] mag_d;
  logic [SumW-1:0]            sum_d;
  logic [SumW:0]              dev_d;

  always_comb begin
    for (int n = 0; n < NumC; n++) begin
      mag_d[n] = data_i[n*CompW+CompW-1] ? (~data_i[n*CompW +: CompW] + CompW'(1))
                                         : data_i[n*CompW +: CompW];
    end
    sum_d = SumW'(s1_sq_q[0]) + SumW'(s1_sq_q[1]) + SumW'(s1_sq_q[2]) + SumW'(s1_sq_q[3]);
    dev_d = ({1'b0, sum_d} > OneQ) ? ({1'b0, sum_d} - OneQ) : (OneQ - {1'b0, sum_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < NumC; n++) begin
        s1_neg_q[n] <= data_i[n*CompW+CompW-1];
        s1_sq_q[n]  <= mag_d[n] * mag_d[n];
      end
      s2_q.neg   <= s1_neg_q;
      s2_q.sq    <= s1_sq_q;
      s2_q.sum   <= sum_d;
      s2_q.ident <= sum_d <= zero_thr_i;
      s2_q.chg   <= (sum_d <= zero_thr_i) || (dev_d > (SumW+1)'(chg_tol_i));
    end
  end

  assign vld_o  = s2_vld_q;
  assign item_o = s2_q;
endmodule

// ===== rtl/qn_fifo.sv =====
// Short queue of classified words between front and back end.
// Depends on qn_pkg.
module qn_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qn_pkg::item_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output qn_pkg::item_t item_o
);
  import qn_pkg::*;

  item_t             mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoAw:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + FifoAw'(1) : wr_q;
    rd_d  = pop_i ? rd_q + FifoAw'(1) : rd_q;
    cnt_d = cnt_q + (FifoAw+1)'(push_i) - (FifoAw+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign full_o = cnt_q == (FifoAw+1)'(FifoDepth);
  assign vld_o  = cnt_q != '0;
  assign item_o = mem_q[rd_q];
endmodule

// ===== rtl/qn_back.sv =====
// Back end: one stage per result bit of round(c * 2^F / sqrt(S)), then the output register.
// Depends on qn_pkg.
module qn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  qn_pkg::item_t item_i,
  output logic          pop_o,
  output logic          vld_o,
  input  logic          ready_i,
  output logic [63:0]   data_o,
  output logic [1:0]    user_o
);
  import qn_pkg::*;

  logic                       en;
  logic                       vld_q   [NumStg+1];
  acc_t                       acc_q   [NumStg+1][NumC];
  logic [FracB:0]             res_q   [NumStg+1][NumC];
  logic [AccW-1:0]            m_q     [NumStg+1][NumC];
  logic [AccW-1:0]            s_q     [NumStg+1];
  logic [NumC-1:0]            neg_q   [NumStg+1];
  logic                       ident_q [NumStg+1];
  logic                       chg_q   [NumStg+1];
  logic                       out_vld_q;
  logic [63:0]                out_data_q;
  logic [1:0]                 out_user_q;
  logic [NumC-1:0][CompW-1:0] comp_d;

  assign en    = !out_vld_q || ready_i;
  assign pop_o = en && vld_i;

  always_comb begin
    for (int n = 0; n < NumC; n++) begin
      comp_d[n] = neg_q[NumStg][n] ? (~CompW'(res_q[NumStg][n]) + CompW'(1))
                                   : CompW'(res_q[NumStg][n]);
    end
    if (ident_q[NumStg]) begin
      comp_d    = '0;
      comp_d[0] = CompW'(1) << FracB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NumStg; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= vld_i;
      for (int k = 0; k < NumStg; k++) vld_q[k+1] <= vld_q[k];
      out_vld_q <= vld_q[NumStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0]     <= AccW'(item_i.sum);
      neg_q[0]   <= item_i.neg;
      ident_q[0] <= item_i.ident;
      chg_q[0]   <= item_i.chg;
      for (int n = 0; n < NumC; n++) begin
        acc_q[0][n] <= '0;
        res_q[0][n] <= '0;
        m_q[0][n]   <= AccW'(item_i.sq[n]) << (2 * FracB + 2);
      end
      // stage k settles result bit FracB-k
      for (int k = 0; k < NumStg; k++) begin
        s_q[k+1]     <= s_q[k];
        neg_q[k+1]   <= neg_q[k];
        ident_q[k+1] <= ident_q[k];
        chg_q[k+1]   <= chg_q[k];
        for (int n = 0; n < NumC; n++) begin
          m_q[k+1][n] <= m_q[k][n];
          if (try_bit(acc_q[k][n].acc_a, acc_q[k][n].acc_b, s_q[k], m_q[k][n],
                      FracB - k)) begin
            acc_q[k+1][n] <= take_bit(acc_q[k][n], s_q[k], FracB - k);
            res_q[k+1][n] <= res_q[k][n] | ((FracB+1)'(1) << (FracB - k));
          end else begin
            acc_q[k+1][n] <= acc_q[k][n];
            res_q[k+1][n] <= res_q[k][n];
          end
        end
      end
      out_data_q <= comp_d;
      out_user_q <= {chg_q[NumStg], ident_q[NumStg]};
    end
  end

  assign vld_o  = out_vld_q;
  assign data_o = out_data_q;
  assign user_o = out_user_q;
endmodule

// ===== rtl/quaternion_normalize.sv =====
// Top level of the quaternion normalizer: configuration registers, front end, queue, back end.
// Depends on qn_pkg, qn_front, qn_fifo and qn_back.
//
// Takes one Q2.14 quaternion word per cycle and returns one normalized word per cycle when
// the output side keeps up. The path runs through two front stages (squares, then sum
// and classification), the four-word queue, fifteen search stages in the back end (one
// per result bit, each a wide add and compare) and the output register. A word whose squared
// length is at or below zero_threshold comes out as the identity with both flags set.
// The user writes registers with cfg_we_i only while the block is empty; it is not enforced.
module quaternion_normalize (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // in_real, in_i, in_j, in_k
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_real, out_i, out_j, out_k
  output logic [1:0]  m_axis_tuser,   // replaced_with_identity, changed
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [32:0] cfg_data_i
);
  import qn_pkg::*;

  logic [RegW-1:0] zero_thr_q, chg_tol_q;
  logic            front_vld, front_en, fifo_full, fifo_vld, pop;
  item_t           front_item, fifo_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_thr_q <= '0;
      chg_tol_q  <= ChgTolRst;
    end else if (cfg_we_i && !cfg_idx_i[1]) begin
      if (cfg_idx_i[0] == RegZeroThr) zero_thr_q <= cfg_data_i;
      if (cfg_idx_i[0] == RegChgTol)  chg_tol_q  <= cfg_data_i;
    end
  end

  assign front_en      = !(front_vld && fifo_full);
  assign s_axis_tready = front_en;

  qn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (front_en),
    .vld_i      (s_axis_tvalid),
    .data_i     (s_axis_tdata),
    .zero_thr_i (zero_thr_q),
    .chg_tol_i  (chg_tol_q),
    .vld_o      (front_vld),
    .item_o     (front_item)
  );

  qn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld && front_en),
    .item_i (front_item),
    .full_o (fifo_full),
    .pop_i  (pop),
    .vld_o  (fifo_vld),
    .item_o (fifo_item)
  );

  qn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (fifo_vld),
    .item_i  (fifo_item),
    .pop_o   (pop),
    .vld_o   (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser)
  );
endmodule

// ===== tb/sv/quaternion_normalize_test.sv =====
// Self-checking bench for quaternion_normalize: directed and random quaternions with
// random stalls on both streams, predicted results compared field by field. Needs qn_pkg.
`timescale 1ns / 1ps

module quaternion_normalize_test;
  import qn_pkg::*;

  typedef struct packed {
    logic [15:0] k;
    logic [15:0] j;
    logic [15:0] i;
    logic [15:0] r;
  } quat_t;

  typedef struct {
    quat_t q;
    logic  ident;
    logic  chg;
  } norm_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [32:0] cfg_data_i;

  int unsigned errors;
  longint unsigned cycles;
  bit          hold_long;

  quaternion_normalize dut (.*);

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class norm_board;
    logic [32:0] zero_thr;
    logic [32:0] chg_tol;
    norm_t       pending[$];

    function new();
      zero_thr = '0;
      chg_tol  = 33'(2684);
    endfunction

    // largest r in [0, 2^14] with (2r-1)^2 * s <= mag^2 * 2^30, i.e. round half up
    function automatic logic [15:0] scale(input logic [15:0] mag, input logic [63:0] s);
      logic [127:0] lhs, rhs;
      longint unsigned lo, hi, mid, t;
      lo = 0;
      hi = 1 << FracB;
      rhs = 128'(mag) * 128'(mag) << (2 * FracB + 2);
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        t = 2 * mid - 1;
        lhs = 128'(t * t) * 128'(s);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return 16'(lo);
    endfunction

    function void note(input quat_t q);
      logic [15:0] c[4], mag[4];
      logic [63:0] s, one, dev;
      norm_t e;
      c = '{q.r, q.i, q.j, q.k};
      s = 0;
      for (int n = 0; n < 4; n++) begin
        mag[n] = c[n][15] ? 16'(-c[n]) : c[n];
        s += 64'(mag[n]) * 64'(mag[n]);
      end
      if (s <= 64'(zero_thr)) begin
        e.q = '{k: 0, j: 0, i: 0, r: 16'(1 << FracB)};
        e.ident = 1;
        e.chg = 1;
      end else begin
        for (int n = 0; n < 4; n++) begin
          logic [15:0] v;
          v = scale(mag[n], s);
          c[n] = c[n][15] ? 16'(-v) : v;
        end
        e.q = '{k: c[3], j: c[2], i: c[1], r: c[0]};
        e.ident = 0;
        one = 64'(1) << (2 * FracB);
        dev = (s > one) ? s - one : one - s;
        e.chg = dev > 64'(chg_tol);
      end
      pending.push_back(e);
    endfunction

    task check(input logic [63:0] d, input logic [1:0] u);
      norm_t e;
      quat_t g;
      if (pending.size() == 0) begin
        report("unexpected word", d, 0);
        return;
      end
      e = pending.pop_front();
      g = d;
      if (g.r !== e.q.r) report("out_real", g.r, e.q.r);
      if (g.i !== e.q.i) report("out_i", g.i, e.q.i);
      if (g.j !== e.q.j) report("out_j", g.j, e.q.j);
      if (g.k !== e.q.k) report("out_k", g.k, e.q.k);
      if (u[0] !== e.ident) report("replaced_with_identity", u[0], e.ident);
      if (u[1] !== e.chg) report("changed", u[1], e.chg);
    endtask
  endclass

  norm_board board;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata, m_axis_tuser);

  // receiver: random stalls per word, or a long hold when asked
  initial begin
    int w;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk_i);
        hold_long = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        m_axis_tready <= 0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send(input quat_t q, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 8) : 0;
    if (w > 0) begin
      s_axis_tvalid <= 0;
      repeat (w) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= q;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note(q);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [32:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    if (idx == 2'(RegZeroThr)) board.zero_thr = val;
    else if (idx == 2'(RegChgTol)) board.chg_tol = val;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16384)) * ($urandom_range(0, 1) ? -1 : 1));
      default: return 16'($urandom_range(0, 40) - 20);
    endcase
  endfunction

  function automatic quat_t rand_quat();
    int mode;
    mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    return '{r: rand_comp(mode), i: rand_comp(mode), j: rand_comp(mode), k: rand_comp(mode)};
  endfunction

  initial begin
    quat_t dir[$];
    logic [32:0] thr_set[4], tol_set[4];
    board = new();
    errors = 0;
    cycles = 0;
    hold_long = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // zero, identity, most negative, full scale, tiny, single axes, a tie-ish case
    dir = '{'{r: 0, i: 0, j: 0, k: 0}, '{r: 16'h4000, i: 0, j: 0, k: 0},
            '{r: 16'h8000, i: 16'h8000, j: 16'h8000, k: 16'h8000},
            '{r: 16'h7fff, i: 16'h7fff, j: 16'h7fff, k: 16'h7fff},
            '{r: 16'h7fff, i: 16'h8000, j: 16'h7fff, k: 16'h8000},
            '{r: 1, i: 0, j: 0, k: 0}, '{r: 0, i: 16'hffff, j: 0, k: 0},
            '{r: 0, i: 0, j: 16'h8000, k: 0}, '{r: 0, i: 0, j: 0, k: 16'h7fff},
            '{r: 16'h2000, i: 16'h2000, j: 16'h2000, k: 16'h2000},
            '{r: 16'h4001, i: 0, j: 0, k: 0}, '{r: 16'h3fff, i: 0, j: 0, k: 0},
            '{r: 3, i: 16'hfffc, j: 5, k: 0}, '{r: 16'h5555, i: 16'haaaa, j: 1, k: 2}};
    foreach (dir[n]) send(dir[n], 0);
    drain();

    thr_set = '{33'd0, 33'd1000, 33'h1_0000_0000, 33'd268435456};
    tol_set = '{33'd0, 33'h1_ffff_ffff, 33'd2684, 33'd1000000};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(2'(RegZeroThr), thr_set[ph]);
      write_reg(2'(RegChgTol), tol_set[ph]);
      write_reg(2'd3, 33'h1_5555_5555);
      foreach (dir[n]) if (n < 6) send(dir[n], 1);
      for (int n = 0; n < 120; n++) begin
        if (ph == 1 && n == 20) hold_long = 1;
        send(rand_quat(), (ph == 2) ? 0 : 1);
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
